// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the deque modules.
// Each macro samples on the rising edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// The expression must never be true.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== hdl/deq_pkg.sv =====
package deq_pkg;

   // Operation carried by an input item.
   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } opcode_type;

   // Outcome reported with each result item.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   localparam int VALUE_W     = 32;
   localparam int OCCUPANCY_W = 5;

   // Commands from the controller to the datapath; at most one is set.
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
   } deq_cmd_type;

   // Status of the ring as seen by the controller.
   typedef struct packed {
      logic empty;
      logic full;
   } deq_flags_type;

endpackage

// ===== hdl/deq_req_if.sv =====
interface deq_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          opcode;
   logic signed [31:0]  push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

// ===== hdl/deq_rsp_if.sv =====
interface deq_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  popped_value;
   logic [1:0]          status;
   logic [4:0]          occupancy;

   modport source (output valid, output popped_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input popped_value, input status, input occupancy,
                   output ready);
endinterface

// ===== hdl/double_ended_queue.sv =====
// Double-ended queue over a ring store of DEPTH entries.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle unless the receiver stalls; the result register frees as its item is taken.
// The value of a pop comes from the store's single registered read port.
// Reset clears the indices, the count and the result register; the store is not cleared.
module double_ended_queue #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   deq_req_if.sink    req_bus,
   deq_rsp_if.source  rsp_bus
);
   import deq_pkg::*;

   deq_cmd_type   cmd;
   deq_flags_type flags;
   status_type    status;
   logic          pop_ok;

   // Handshake and operation decoding.
   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .flags      (flags),
      .cmd        (cmd),
      .status     (status),
      .pop_ok     (pop_ok)
   );

   // Ring store, indices and count.
   deq_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .push_value   (req_bus.push_value),
      .pop_ok       (pop_ok),
      .flags        (flags),
      .popped_value (rsp_bus.popped_value),
      .occupancy    (rsp_bus.occupancy)
   );

   assign rsp_bus.status = status;

endmodule

// ===== hdl/deq_ctrl.sv =====
`include "assert_macros.svh"

module deq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_opcode,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  deq_pkg::deq_flags_type flags,
   output deq_pkg::deq_cmd_type   cmd,
   output deq_pkg::status_type    status,
   output logic                   pop_ok
);
   import deq_pkg::*;

   typedef enum logic {
      S_EMPTY,
      S_HOLD
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       pop_ok_ff, pop_ok_in;
   logic       accept;
   opcode_type op;

   // A new item is taken whenever the result register is free or being emptied.
   assign req_ready = (state_ff == S_EMPTY) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign op        = opcode_type'(req_opcode);

   // Decode the operation against the ring's flags into at most one datapath command.
   always_comb begin
      cmd       = '0;
      status_in = ST_OK;
      pop_ok_in = 1'b0;
      case (op)
         OP_PUSH_FRONT: begin
            if (flags.full) status_in = ST_OVERFLOW;
            else            cmd.push_front = accept;
         end
         OP_PUSH_BACK: begin
            if (flags.full) status_in = ST_OVERFLOW;
            else            cmd.push_back = accept;
         end
         OP_POP_FRONT: begin
            if (flags.empty) status_in = ST_UNDERFLOW;
            else begin
               cmd.pop_front = accept;
               pop_ok_in     = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (flags.empty) status_in = ST_UNDERFLOW;
            else begin
               cmd.pop_back = accept;
               pop_ok_in    = 1'b1;
            end
         end
         default: status_in = ST_OK;
      endcase
   end

   // Next state of the result register.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_EMPTY: if (accept) state_in = S_HOLD;
         S_HOLD: begin
            if (accept)         state_in = S_HOLD;
            else if (rsp_ready) state_in = S_EMPTY;
         end
         default: state_in = S_EMPTY;
      endcase
   end

   // State and the registered result fields.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_EMPTY;
         status_ff <= ST_OK;
         pop_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            status_ff <= status_in;
            pop_ok_ff <= pop_ok_in;
         end
      end
   end

   assign rsp_valid = (state_ff == S_HOLD);
   assign status    = status_ff;
   assign pop_ok    = pop_ok_ff;

   `ASSERT_CLK(a_one_cmd, $onehot0({cmd.push_front, cmd.push_back, cmd.pop_front, cmd.pop_back}), "more than one datapath command")
   `ASSERT_CLK(a_accept_gives_rsp, accept |=> rsp_valid, "accepted item produced no result")
   `ASSERT_CLK(a_stall_holds, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status_ff)), "stalled result lost")
   `ASSERT_NEVER(a_pop_ok_status, pop_ok_ff && (status_ff != ST_OK), "pop data flagged with bad status")

endmodule

// ===== hdl/deq_dpath.sv =====
`include "assert_macros.svh"

module deq_dpath #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  deq_pkg::deq_cmd_type                  cmd,
   input  logic signed [deq_pkg::VALUE_W-1:0]    push_value,
   input  logic                                  pop_ok,
   output deq_pkg::deq_flags_type                flags,
   output logic signed [deq_pkg::VALUE_W-1:0]    popped_value,
   output logic [deq_pkg::OCCUPANCY_W-1:0]       occupancy
);
   import deq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [IDX_W-1:0] front_dec, back_dec;
   logic [IDX_W+1:0] ring_sum, ring_back;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
   endfunction

   assign flags.empty = (count_ff == '0);
   assign flags.full  = (count_ff == CNT_W'(DEPTH));

   assign front_dec = idx_dec(front_ff);
   assign back_dec  = idx_dec(back_ff);

   // Index, count and store port control for the current command.
   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      wr_addr  = back_ff;
      rd_addr  = front_ff;
      if (cmd.push_front) begin
         front_in = front_dec;
         wr_en    = 1'b1;
         wr_addr  = front_dec;
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.push_back) begin
         back_in  = idx_inc(back_ff);
         wr_en    = 1'b1;
         wr_addr  = back_ff;
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop_front) begin
         front_in = idx_inc(front_ff);
         rd_en    = 1'b1;
         rd_addr  = front_ff;
         count_in = count_ff - CNT_W'(1);
      end else if (cmd.pop_back) begin
         back_in  = back_dec;
         rd_en    = 1'b1;
         rd_addr  = back_dec;
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Ring store with one write and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= DATA_WIDTH'(push_value);
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // Ring indices and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   // The popped value is the stored entry sign-extended, or zero when nothing was popped.
   assign popped_value = pop_ok ? VALUE_W'(signed'(rd_data_ff)) : '0;
   assign occupancy    = OCCUPANCY_W'(count_ff);

   // Where the back index should sit given the front index and the count.
   always_comb begin
      ring_sum  = (IDX_W + 2)'(front_ff) + (IDX_W + 2)'(count_ff);
      ring_back = (ring_sum >= (IDX_W + 2)'(DEPTH)) ? ring_sum - (IDX_W + 2)'(DEPTH) : ring_sum;
   end

   `ASSERT_NEVER(a_count_bound, count_ff > CNT_W'(DEPTH), "occupancy beyond depth")
   `ASSERT_CLK(a_ring_consistent, ring_back == (IDX_W + 2)'(back_ff), "indices disagree with count")
   `ASSERT_CLK(a_push_counts, (cmd.push_front || cmd.push_back) |=> (count_ff == $past(count_ff) + CNT_W'(1)), "push did not raise the count")

endmodule

// ===== sim/double_ended_queue_test.sv =====
module double_ended_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   localparam int DEPTH         = 16;
   localparam int DATA_WIDTH    = 32;
   localparam int RANDOM_ITEMS  = 1050;
   localparam int LATENCY       = 1;
   localparam int CYCLE_LIMIT   = 200000;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

   // Bias of the random walk, so that the ring is driven to full and to empty.
   typedef enum int {
      WALK_FILL,
      WALK_DRAIN,
      WALK_BALANCED
   } walk_mode_type;

   // What one result item is expected to carry.
   typedef struct {
      logic signed [31:0]       popped_value;
      status_type               status;
      logic [OCCUPANCY_W-1:0]   occupancy;
   } deque_outcome_type;

   logic clock = 1'b0;
   logic reset;

   deq_req_if req_bus ();
   deq_rsp_if rsp_bus ();

   double_ended_queue #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow copy of the ring, kept in step with every accepted item.
   logic signed [31:0] ring_copy [DEPTH];
   int                 front_slot = 0;
   int                 back_slot  = 0;
   int                 held_count = 0;

   deque_outcome_type  awaited_outcomes [$];
   int                 error_count  = 0;
   int                 cycle_count  = 0;
   int                 burst_left   = 1;
   logic [15:0]        stall_pattern = 16'hFFFF;
   int                 pattern_age  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the result of one operation and updates the shadow ring.
   function automatic deque_outcome_type apply_deque_op(input opcode_type op,
                                                        input logic signed [31:0] value);
      deque_outcome_type outcome;
      outcome.popped_value = '0;
      outcome.status       = ST_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (held_count >= DEPTH) begin
               outcome.status = ST_OVERFLOW;
            end else if (op == OP_PUSH_FRONT) begin
               front_slot = (front_slot + DEPTH - 1) % DEPTH;
               ring_copy[front_slot] = value;
               held_count++;
            end else begin
               ring_copy[back_slot] = value;
               back_slot = (back_slot + 1) % DEPTH;
               held_count++;
            end
         end
         default: begin
            if (held_count == 0) begin
               outcome.status = ST_UNDERFLOW;
            end else if (op == OP_POP_FRONT) begin
               outcome.popped_value = ring_copy[front_slot];
               front_slot = (front_slot + 1) % DEPTH;
               held_count--;
            end else begin
               back_slot = (back_slot + DEPTH - 1) % DEPTH;
               outcome.popped_value = ring_copy[back_slot];
               held_count--;
            end
         end
      endcase
      outcome.occupancy = OCCUPANCY_W'(held_count);
      return outcome;
   endfunction

   function automatic logic signed [31:0] edge_value(input int k);
      case (k % 4)
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   // Mostly random values, with the extremes, zero or minus one now and then.
   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(0, 7) == 0) begin
         return edge_value($urandom_range(0, 3));
      end
      return $urandom;
   endfunction

   // Offers one item from a falling edge, waits until it is taken and records its
   // expected result. Valid is left high unless the burst ends with a gap.
   task automatic send_item(input opcode_type op, input logic signed [31:0] value);
      int gap;
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.push_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      awaited_outcomes.push_back(apply_deque_op(op, value));
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 6);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // Holds the sender back until every outstanding result has been seen.
   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (awaited_outcomes.size() != 0);
   endtask

   // Pops from both ends of an empty queue.
   task automatic test_empty_pops();
      send_item(OP_POP_FRONT, VALUE_MAX);
      send_item(OP_POP_BACK, VALUE_MIN);
   endtask

   // Fills the ring from both ends, so the front index wraps below zero.
   task automatic test_fill_with_extremes();
      for (int i = 0; i < DEPTH; i++) begin
         send_item((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                   (i < 4) ? edge_value(i) : pick_value());
      end
   endtask

   // Pushes at either end of a full queue must be dropped.
   task automatic test_overflow_both_ends();
      send_item(OP_PUSH_FRONT, VALUE_MAX);
      send_item(OP_PUSH_BACK, VALUE_MIN);
   endtask

   task automatic test_pop_both_ends();
      send_item(OP_POP_FRONT, 32'sd0);
      send_item(OP_POP_BACK, 32'sd0);
      send_item(OP_POP_FRONT, -32'sd1);
      send_item(OP_POP_BACK, VALUE_MAX);
   endtask

   // Random walk in segments that lean towards filling, draining or neither.
   task automatic test_random_walk();
      int            sent;
      int            segment_len;
      int            push_percent;
      walk_mode_type mode;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode = walk_mode_type'($urandom_range(0, 2));
         case (mode)
            WALK_FILL:  push_percent = 85;
            WALK_DRAIN: push_percent = 15;
            default:    push_percent = 50;
         endcase
         segment_len = $urandom_range(8, 48);
         for (int i = 0; i < segment_len; i++) begin
            if ($urandom_range(0, 99) < push_percent) begin
               send_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
            end else begin
               send_item($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, pick_value());
            end
         end
         sent += segment_len;
         if ($urandom_range(0, 11) == 0) begin
            wait_results_drained();
         end
      end
   endtask

   // The receiver stalls on a rotating pattern that is reloaded now and then.
   always @(negedge clock) begin
      if (pattern_age == 0) begin
         stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                     : (16'($urandom) | 16'h0101);
         pattern_age   = $urandom_range(16, 96);
      end else begin
         pattern_age--;
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
      rsp_bus.ready <= stall_pattern[0];
   end

   // Compares each result item with the oldest expectation.
   always @(posedge clock) begin : result_check
      deque_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_outcomes.size() == 0) begin
            $display({"%0t: result item with none expected: ",
                      "popped_value %0d status %0d occupancy %0d"},
                     $time, rsp_bus.popped_value, rsp_bus.status, rsp_bus.occupancy);
            error_count++;
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_bus.popped_value !== want.popped_value) begin
               $display("%0t: popped_value mismatch: expected %0d, actual %0d",
                        $time, want.popped_value, rsp_bus.popped_value);
               error_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.occupancy !== want.occupancy) begin
               $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                        $time, want.occupancy, rsp_bus.occupancy);
               error_count++;
            end
         end
      end
   end

   // Guards against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OP_PUSH_FRONT;
      req_bus.push_value <= '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_empty_pops();
      test_fill_with_extremes();
      test_overflow_both_ends();
      test_pop_both_ends();
      wait_results_drained();
      test_random_walk();

      // Let the last results through, then allow for the pipeline latency.
      wait_results_drained();
      repeat (LATENCY + 4) @(posedge clock);
      if (awaited_outcomes.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, awaited_outcomes.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_req_if.sv
hdl/deq_rsp_if.sv
hdl/deq_ctrl.sv
hdl/deq_dpath.sv
hdl/double_ended_queue.sv
sim/double_ended_queue_test.sv
